// ----- sv/bre_pkg.sv -----
// ----------------------------------------------------------------------------
// bre_pkg
// Shared types and constants of the BMP RLE8 row encoder.
// ----------------------------------------------------------------------------
package bre_pkg;

  localparam int unsigned LIT_LIMIT  = 255;
  localparam int unsigned SHORT_RUN  = 3;
  localparam int unsigned RUN_CAP    = 8191;
  localparam int unsigned RUN_W      = 13;
  localparam int unsigned FIFO_DEPTH = 4;

  typedef enum logic [2:0] {
    OP_LIT    = 3'd0,  // store val at num, flag: flush a full group after
    OP_FLUSH  = 3'd1,  // emit the literal group of num bytes
    OP_RUN    = 3'd2,  // emit a coded run of num copies of val
    OP_ROWEND = 3'd3,  // emit 0,0 and, with flag, 0,1
    OP_END    = 3'd4   // close the result words of one request
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [7:0]       val;
    logic [RUN_W-1:0] num;
    logic             flag;
  } cmd_t;

endpackage

// ----- sv/bre_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// bre_cmd_fifo
// Small command queue between the classifier and the byte generator.
// ----------------------------------------------------------------------------
module bre_cmd_fifo import bre_pkg::*; #(
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          store_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_cmd = store_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("command pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
    else $error("command popped from empty queue");

endmodule

// ----- sv/bre_front.sv -----
// ----------------------------------------------------------------------------
// bre_front
// Tracks the open run and the literal count and turns each pixel request
// into a short list of commands for the byte generator.
// ----------------------------------------------------------------------------
module bre_front import bre_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_pixel,
  input  logic       in_row_end,
  input  logic       in_image_end,
  output logic       q_push,
  output cmd_t       q_cmd,
  input  logic       q_full
);

  typedef enum logic [9:0] {
    F_IDLE   = 10'b00_0000_0001,
    F_MATCH  = 10'b00_0000_0010,
    F_CLOSE  = 10'b00_0000_0100,
    F_CLRUN  = 10'b00_0000_1000,
    F_NEWRUN = 10'b00_0001_0000,
    F_CAP    = 10'b00_0010_0000,
    F_ROW    = 10'b00_0100_0000,
    F_RFLUSH = 10'b00_1000_0000,
    F_REND   = 10'b01_0000_0000,
    F_FIN    = 10'b10_0000_0000
  } fstate_t;

  fstate_t          st_r, st_nxt, ret_r, ret_nxt;
  logic [7:0]       px_r, px_nxt;
  logic             re_r, re_nxt, ie_r, ie_nxt;
  logic [7:0]       lc_r, lc_nxt;
  logic [7:0]       rv_r, rv_nxt;
  logic [RUN_W-1:0] rl_r, rl_nxt;
  logic             want;

  assign in_ready = (st_r == F_IDLE);
  assign q_push   = want && !q_full;

  always_comb begin
    st_nxt  = st_r;
    ret_nxt = ret_r;
    px_nxt  = px_r;
    re_nxt  = re_r;
    ie_nxt  = ie_r;
    lc_nxt  = lc_r;
    rv_nxt  = rv_r;
    rl_nxt  = rl_r;
    want    = 1'b0;
    q_cmd   = '{op: OP_FLUSH, val: rv_r, num: RUN_W'(lc_r), flag: 1'b0};
    case (st_r)
      F_IDLE: begin
        if (in_valid) begin
          px_nxt = in_pixel;
          re_nxt = in_row_end;
          ie_nxt = in_image_end;
          st_nxt = F_MATCH;
        end
      end
      F_MATCH: begin
        if (rl_r != '0 && px_r == rv_r) begin
          // third equal pixel: the pending group goes out ahead of the run
          if (rl_r + 1'b1 == RUN_W'(SHORT_RUN)) begin
            want = 1'b1;
            if (!q_full) begin
              lc_nxt = '0;
              rl_nxt = rl_r + 1'b1;
              st_nxt = F_CAP;
            end
          end else begin
            rl_nxt = rl_r + 1'b1;
            st_nxt = F_CAP;
          end
        end else begin
          ret_nxt = F_NEWRUN;
          st_nxt  = F_CLOSE;
        end
      end
      F_CLOSE: begin
        if (rl_r == '0) begin
          st_nxt = ret_r;
        end else if (rl_r >= RUN_W'(SHORT_RUN)) begin
          want = 1'b1;
          if (!q_full) begin
            lc_nxt = '0;
            st_nxt = F_CLRUN;
          end
        end else begin
          // short run: each pixel joins the literal group
          want  = 1'b1;
          q_cmd = '{op: OP_LIT, val: rv_r, num: RUN_W'(lc_r),
                    flag: (lc_r == 8'(LIT_LIMIT - 1))};
          if (!q_full) begin
            lc_nxt = (lc_r == 8'(LIT_LIMIT - 1)) ? '0 : lc_r + 1'b1;
            rl_nxt = rl_r - 1'b1;
          end
        end
      end
      F_CLRUN: begin
        want  = 1'b1;
        q_cmd = '{op: OP_RUN, val: rv_r, num: rl_r, flag: 1'b0};
        if (!q_full) begin
          rl_nxt = '0;
          st_nxt = ret_r;
        end
      end
      F_NEWRUN: begin
        rv_nxt = px_r;
        rl_nxt = RUN_W'(1);
        st_nxt = F_CAP;
      end
      F_CAP: begin
        if (rl_r >= RUN_W'(RUN_CAP)) begin
          ret_nxt = F_ROW;
          st_nxt  = F_CLOSE;
        end else begin
          st_nxt = F_ROW;
        end
      end
      F_ROW: begin
        if (re_r || ie_r) begin
          ret_nxt = F_RFLUSH;
          st_nxt  = F_CLOSE;
        end else begin
          st_nxt = F_FIN;
        end
      end
      F_RFLUSH: begin
        want = 1'b1;
        if (!q_full) begin
          lc_nxt = '0;
          st_nxt = F_REND;
        end
      end
      F_REND: begin
        want  = 1'b1;
        q_cmd = '{op: OP_ROWEND, val: rv_r, num: '0, flag: ie_r};
        if (!q_full) begin
          st_nxt = F_FIN;
        end
      end
      F_FIN: begin
        want  = 1'b1;
        q_cmd = '{op: OP_END, val: rv_r, num: '0, flag: 1'b0};
        if (!q_full) begin
          st_nxt = F_IDLE;
        end
      end
      default: begin
        st_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= F_IDLE;
      ret_r <= F_FIN;
      lc_r  <= '0;
      rv_r  <= '0;
      rl_r  <= '0;
    end else begin
      st_r  <= st_nxt;
      ret_r <= ret_nxt;
      lc_r  <= lc_nxt;
      rv_r  <= rv_nxt;
      rl_r  <= rl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r <= px_nxt;
    re_r <= re_nxt;
    ie_r <= ie_nxt;
  end

endmodule

// ----- sv/bre_back.sv -----
// ----------------------------------------------------------------------------
// bre_back
// Executes commands: keeps the literal store, generates at most one byte per
// cycle and packs the bytes into 8-byte result words.
// ----------------------------------------------------------------------------
module bre_back import bre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  cmd_t        q_cmd,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last
);

  typedef enum logic [11:0] {
    B_IDLE   = 12'b0000_0000_0001,
    B_FSTART = 12'b0000_0000_0010,
    B_FLEN   = 12'b0000_0000_0100,
    B_FDAT   = 12'b0000_0000_1000,
    B_FPAD   = 12'b0000_0001_0000,
    B_SPRE   = 12'b0000_0010_0000,
    B_SDAT   = 12'b0000_0100_0000,
    B_RCNT   = 12'b0000_1000_0000,
    B_RVAL   = 12'b0001_0000_0000,
    B_E0     = 12'b0010_0000_0000,
    B_E1     = 12'b0100_0000_0000,
    B_END    = 12'b1000_0000_0000
  } bstate_t;

  bstate_t          st_r, st_nxt;
  logic [7:0]       val_r, val_nxt;
  logic [RUN_W-1:0] n_r, n_nxt;
  logic             flag_r, flag_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       rd_r;
  logic [7:0]       mem_r [LIT_LIMIT];
  logic             mem_we;
  logic [7:0]       chunk;
  logic             tail;

  logic             byte_req, byte_ok, fin_req, fin_ok, out_free;
  logic [7:0]       byte_val;
  logic [63:0]      word_r, word_nxt;
  logic [3:0]       pk_cnt_r, pk_cnt_nxt;
  logic             ov_r, ov_nxt, ol_r, ol_nxt;
  logic [63:0]      ow_r, ow_nxt;
  logic [3:0]       oc_r, oc_nxt;

  assign out_valid      = ov_r;
  assign out_bytes      = ow_r;
  assign out_byte_count = oc_r;
  assign out_last       = ol_r;

  assign out_free = !ov_r || out_ready;
  assign byte_ok  = (pk_cnt_r != 4'd8) || out_free;
  assign fin_ok   = (pk_cnt_r == 4'd0) || out_free;
  assign chunk    = (n_r > RUN_W'(LIT_LIMIT)) ? 8'(LIT_LIMIT) : n_r[7:0];
  assign tail     = (RUN_W'(idx_r) + 1'b1 == n_r);

  always_comb begin
    st_nxt   = st_r;
    val_nxt  = val_r;
    n_nxt    = n_r;
    flag_nxt = flag_r;
    idx_nxt  = idx_r;
    q_pop    = 1'b0;
    mem_we   = 1'b0;
    byte_req = 1'b0;
    byte_val = 8'd0;
    fin_req  = 1'b0;
    case (st_r)
      B_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          val_nxt  = q_cmd.val;
          n_nxt    = q_cmd.num;
          flag_nxt = q_cmd.flag;
          idx_nxt  = '0;
          case (q_cmd.op)
            OP_LIT: begin
              mem_we = 1'b1;
              if (q_cmd.flag) begin
                n_nxt  = RUN_W'(LIT_LIMIT);
                st_nxt = B_FSTART;
              end
            end
            OP_FLUSH:  st_nxt = (q_cmd.num == '0) ? B_IDLE : B_FSTART;
            OP_RUN:    st_nxt = B_RCNT;
            OP_ROWEND: st_nxt = B_E0;
            OP_END:    st_nxt = B_END;
            default:   st_nxt = B_IDLE;
          endcase
        end
      end
      B_FSTART: begin
        if (n_r > RUN_W'(SHORT_RUN)) begin
          byte_req = 1'b1;
          if (byte_ok) st_nxt = B_FLEN;
        end else begin
          st_nxt = B_SPRE;
        end
      end
      B_FLEN: begin
        byte_req = 1'b1;
        byte_val = n_r[7:0];
        if (byte_ok) st_nxt = B_FDAT;
      end
      B_FDAT: begin
        byte_req = 1'b1;
        byte_val = rd_r;
        if (byte_ok) begin
          if (tail) begin
            st_nxt = n_r[0] ? B_FPAD : B_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
          end
        end
      end
      B_FPAD: begin
        byte_req = 1'b1;
        if (byte_ok) st_nxt = B_IDLE;
      end
      B_SPRE: begin
        byte_req = 1'b1;
        byte_val = 8'd1;
        if (byte_ok) st_nxt = B_SDAT;
      end
      B_SDAT: begin
        byte_req = 1'b1;
        byte_val = rd_r;
        if (byte_ok) begin
          if (tail) begin
            st_nxt = B_IDLE;
          end else begin
            idx_nxt = idx_r + 1'b1;
            st_nxt  = B_SPRE;
          end
        end
      end
      B_RCNT: begin
        byte_req = 1'b1;
        byte_val = chunk;
        if (byte_ok) st_nxt = B_RVAL;
      end
      B_RVAL: begin
        byte_req = 1'b1;
        byte_val = val_r;
        if (byte_ok) begin
          n_nxt  = n_r - RUN_W'(chunk);
          st_nxt = (n_r == RUN_W'(chunk)) ? B_IDLE : B_RCNT;
        end
      end
      B_E0: begin
        byte_req = 1'b1;
        if (byte_ok) st_nxt = B_E1;
      end
      B_E1: begin
        // second byte of 0,0; image end reuses this pair for 0,1
        byte_req = 1'b1;
        byte_val = (flag_r && n_r[0]) ? 8'd1 : 8'd0;
        if (byte_ok) begin
          if (flag_r && !n_r[0]) begin
            n_nxt  = RUN_W'(1);
            st_nxt = B_E0;
          end else begin
            st_nxt = B_IDLE;
          end
        end
      end
      B_END: begin
        fin_req = 1'b1;
        if (fin_ok) st_nxt = B_IDLE;
      end
      default: begin
        st_nxt = B_IDLE;
      end
    endcase
  end

  // packer: a full word is held until the next byte or the end command
  always_comb begin
    word_nxt   = word_r;
    pk_cnt_nxt = pk_cnt_r;
    ov_nxt     = ov_r && !out_ready;
    ow_nxt     = ow_r;
    oc_nxt     = oc_r;
    ol_nxt     = ol_r;
    if (byte_req && byte_ok) begin
      if (pk_cnt_r == 4'd8) begin
        ov_nxt     = 1'b1;
        ow_nxt     = word_r;
        oc_nxt     = 4'd8;
        ol_nxt     = 1'b0;
        word_nxt   = {56'd0, byte_val};
        pk_cnt_nxt = 4'd1;
      end else begin
        word_nxt[pk_cnt_r[2:0]*8 +: 8] = byte_val;
        pk_cnt_nxt = pk_cnt_r + 1'b1;
      end
    end else if (fin_req && fin_ok && pk_cnt_r != 4'd0) begin
      ov_nxt     = 1'b1;
      ow_nxt     = word_r;
      oc_nxt     = pk_cnt_r;
      ol_nxt     = 1'b1;
      word_nxt   = '0;
      pk_cnt_nxt = 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= B_IDLE;
      pk_cnt_r <= '0;
      word_r   <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pk_cnt_r <= pk_cnt_nxt;
      word_r   <= word_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    n_r    <= n_nxt;
    flag_r <= flag_nxt;
    idx_r  <= idx_nxt;
    ow_r   <= ow_nxt;
    oc_r   <= oc_nxt;
    ol_r   <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[q_cmd.num[7:0]] <= q_cmd.val;
    end
    rd_r <= mem_r[idx_nxt];
  end

  a_pack_bound: assert property (@(posedge clk) disable iff (!rst_n) pk_cnt_r <= 4'd8)
    else $error("packer count out of range");
  a_out_count: assert property (@(posedge clk) disable iff (!rst_n)
      ov_r |-> (oc_r != 4'd0 && oc_r <= 4'd8))
    else $error("result word with bad byte count");
  a_partial_last: assert property (@(posedge clk) disable iff (!rst_n)
      (ov_r && oc_r != 4'd8) |-> ol_r)
    else $error("partial word not marked last");
  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
      (st_r == B_FDAT || st_r == B_SDAT) |-> (RUN_W'(idx_r) < n_r))
    else $error("literal index beyond group");

endmodule

// ----- sv/bmp_rle8_row_encoder_unit.sv -----
// ----------------------------------------------------------------------------
// bmp_rle8_row_encoder_unit
// BMP RLE8 encoder for a pixel stream, result words of up to eight bytes.
// ----------------------------------------------------------------------------
// One pixel is taken per request, the next only once the classifier is
// back in idle; it needs more states when a short run spills into the
// literal group or the row closes, and waits while the queue is full. The
// byte generator behind the 4-entry command queue emits at most one byte
// per cycle, two bytes per literal in short groups; a flush of a full
// 255-byte group thus holds the queue and back-pressures the pixel input.
// Bytes of one pixel are packed into words, the final word of each pixel
// carries out_last. The literal store needs no clearing.
module bmp_rle8_row_encoder_unit import bre_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel,
  input  logic        in_row_end,
  input  logic        in_image_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  out_byte_count,
  output logic        out_last
);

  logic q_push, q_full, q_pop, q_empty;
  cmd_t push_cmd, pop_cmd;

  bre_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .in_row_end   (in_row_end),
    .in_image_end (in_image_end),
    .q_push       (q_push),
    .q_cmd        (push_cmd),
    .q_full       (q_full)
  );

  bre_cmd_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .pop_cmd  (pop_cmd),
    .empty    (q_empty)
  );

  bre_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (pop_cmd),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_bytes      (out_bytes),
    .out_byte_count (out_byte_count),
    .out_last       (out_last)
  );

endmodule
